[design/mtep_pkg.sv]
// Shared types, codes and helpers for the MIDI track event parser.
package mtep_pkg;

   // Parser phase
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_HEADER = 4'd1,
      PH_DELTA  = 4'd2,
      PH_STATUS = 4'd3,
      PH_DATA1  = 4'd4,
      PH_DATA2  = 4'd5,
      PH_MTYPE  = 4'd6,
      PH_LEN    = 4'd7,
      PH_SKIP   = 4'd8,
      PH_ERROR  = 4'd9
   } phase_type;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_CHAN = 2'd0,
      KIND_META = 2'd1,
      KIND_END  = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_ESC  = 8'hF7;
   localparam logic [7:0] STATUS_META       = 8'hFF;
   localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
   localparam logic [3:0] HI_PROG_CHANGE    = 4'hC;
   localparam logic [3:0] HI_CHAN_PRESSURE  = 4'hD;

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [27:0] delta_ticks;
      logic [23:0] short_message;
      logic [7:0]  meta_type;
   } rsp_beat_type;

   // Result offered by the parser for the accepted byte
   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } result_type;

   // Program change and channel pressure carry a single data byte
   function automatic logic one_data_byte(input logic [7:0] st);
      return (st[7:4] == HI_PROG_CHANGE) || (st[7:4] == HI_CHAN_PRESSURE);
   endfunction

endpackage

[design/mtep_ifs.sv]
// Valid/ready channel interfaces for track bytes and parsed events.
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_start;

   modport source (output valid, output data_byte, output chunk_start, input ready);
   modport sink (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [27:0] delta_ticks;
   logic [23:0] short_message;
   logic [7:0]  meta_type;

   modport source (output valid, output kind, output delta_ticks, output short_message,
                   output meta_type, input ready);
   modport sink (input valid, input kind, input delta_ticks, input short_message,
                 input meta_type, output ready);
endinterface

[design/mtep_parser.sv]
// Track byte decoder: parse state registers and the per-byte update logic.
module mtep_parser #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                chunk_start,
   output mtep_pkg::result_type result
);
   import mtep_pkg::*;

   localparam int VCNT_W = $clog2(MAX_VLQ_BYTES + 1);

   phase_type         phase_ff, phase_in;
   logic [2:0]        hdr_ff, hdr_in;
   logic [31:0]       chunk_len_ff, chunk_len_in;
   logic [31:0]       seen_ff, seen_in;
   logic [7:0]        run_ff, run_in;
   logic [7:0]        first_ff, first_in;
   logic [27:0]       delta_ff, delta_in;
   logic [27:0]       len_ff, len_in;
   logic [VCNT_W-1:0] vcnt_ff, vcnt_in;
   logic [7:0]        meta_ff, meta_in;

   logic [27:0]       vlq_src, vlq_acc;
   logic [VCNT_W-1:0] vcnt_inc;
   logic              vlq_fin, vlq_over;
   logic              st_chan, st_meta, st_sysex;
   logic [2:0]        hdr_inc;
   logic              hdr_last;
   logic [31:0]       chunk_len_hdr, seen_inc;

   logic              body, ev_done, ev_err, ev_end;
   kind_type          ev_kind;
   logic [23:0]       ev_msg;
   logic [7:0]        ev_mt;

   // Shared decode of the incoming byte
   assign vlq_src       = (phase_ff == PH_LEN) ? len_ff : delta_ff;
   assign vlq_acc       = {vlq_src[20:0], data_byte[6:0]};
   assign vcnt_inc      = vcnt_ff + VCNT_W'(1);
   assign vlq_fin       = !data_byte[7];
   assign vlq_over      = data_byte[7] && (vcnt_inc >= VCNT_W'(MAX_VLQ_BYTES));
   assign st_chan       = data_byte[7] && (data_byte < STATUS_SYSEX);
   assign st_meta       = (data_byte == STATUS_META);
   assign st_sysex      = (data_byte == STATUS_SYSEX) || (data_byte == STATUS_SYSEX_ESC);
   assign hdr_inc       = hdr_ff + 3'd1;
   assign hdr_last      = (hdr_inc == 3'd0);
   assign chunk_len_hdr = hdr_ff[2] ? {chunk_len_ff[23:0], data_byte} : chunk_len_ff;
   assign seen_inc      = seen_ff + 32'd1;

   // Datapath update and result for one byte
   always_comb begin
      delta_in     = delta_ff;
      len_in       = len_ff;
      vcnt_in      = vcnt_ff;
      run_in       = run_ff;
      first_in     = first_ff;
      meta_in      = meta_ff;
      seen_in      = seen_ff;
      chunk_len_in = chunk_len_ff;
      hdr_in       = hdr_ff;
      body         = 1'b0;
      ev_done      = 1'b0;
      ev_err       = 1'b0;
      ev_end       = 1'b0;
      ev_kind      = KIND_CHAN;
      ev_msg       = '0;
      ev_mt        = '0;
      result       = '0;

      if (chunk_start) begin
         hdr_in       = 3'd1;
         chunk_len_in = '0;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               chunk_len_in = chunk_len_hdr;
               hdr_in       = hdr_inc;
               if (hdr_last) begin
                  seen_in  = '0;
                  run_in   = '0;
                  first_in = '0;
                  delta_in = '0;
                  len_in   = '0;
                  vcnt_in  = '0;
                  meta_in  = '0;
                  if (chunk_len_hdr == 32'd0) begin
                     result.valid     = 1'b1;
                     result.beat.kind = KIND_END;
                  end
               end
            end
            PH_DELTA: begin
               body     = 1'b1;
               delta_in = vlq_acc;
               if (vlq_fin) begin
                  vcnt_in = '0;
               end else if (vlq_over) begin
                  ev_err = 1'b1;
               end else begin
                  vcnt_in = vcnt_inc;
               end
            end
            PH_STATUS: begin
               body = 1'b1;
               if (data_byte[7]) begin
                  if (st_chan) begin
                     run_in  = data_byte;
                     meta_in = '0;
                  end else if (st_meta) begin
                     run_in  = '0;
                     meta_in = '0;
                  end else if (st_sysex) begin
                     run_in  = '0;
                     meta_in = data_byte;
                     len_in  = '0;
                     vcnt_in = '0;
                  end else begin
                     ev_err = 1'b1;
                  end
               end else if (run_ff == 8'd0) begin
                  ev_err = 1'b1;
               end else begin
                  // Running status: this byte is the first data byte
                  first_in = data_byte;
                  if (one_data_byte(run_ff)) begin
                     ev_done = 1'b1;
                     ev_msg  = {8'h00, data_byte, run_ff};
                  end
               end
            end
            PH_DATA1: begin
               body     = 1'b1;
               first_in = data_byte;
               if (one_data_byte(run_ff)) begin
                  ev_done = 1'b1;
                  ev_msg  = {8'h00, data_byte, run_ff};
               end
            end
            PH_DATA2: begin
               body    = 1'b1;
               ev_done = 1'b1;
               ev_msg  = {data_byte, first_ff, run_ff};
            end
            PH_MTYPE: begin
               body    = 1'b1;
               meta_in = data_byte;
               len_in  = '0;
               vcnt_in = '0;
            end
            PH_LEN: begin
               body   = 1'b1;
               len_in = vlq_acc;
               if (vlq_fin) begin
                  vcnt_in = '0;
                  if (vlq_acc == 28'd0) begin
                     ev_done = 1'b1;
                     ev_kind = KIND_META;
                  end
               end else if (vlq_over) begin
                  ev_err = 1'b1;
               end else begin
                  vcnt_in = vcnt_inc;
               end
            end
            PH_SKIP: begin
               body   = 1'b1;
               len_in = len_ff - 28'd1;
               if (len_in == 28'd0) begin
                  ev_done = 1'b1;
                  ev_kind = KIND_META;
               end
            end
            default: ;
         endcase

         // Count body bytes, then report error, chunk end or event
         if (body) begin
            seen_in = seen_inc;
            ev_mt   = (ev_done && (ev_kind == KIND_CHAN)) ? 8'h00 : meta_in;
            ev_end  = (ev_done && (ev_kind == KIND_META) && (meta_in == META_END_OF_TRACK))
                      || (seen_inc == chunk_len_ff);
            if (ev_err) begin
               result.valid     = 1'b1;
               result.beat.kind = KIND_ERR;
            end else if (ev_end) begin
               result.valid             = 1'b1;
               result.beat.kind         = KIND_END;
               result.beat.delta_ticks  = delta_in;
               result.beat.meta_type    = ev_mt;
            end else if (ev_done) begin
               result.valid              = 1'b1;
               result.beat.kind          = ev_kind;
               result.beat.delta_ticks   = delta_in;
               result.beat.short_message = ev_msg;
               result.beat.meta_type     = ev_mt;
            end
            if (ev_done) begin
               delta_in = '0;
               meta_in  = '0;
               vcnt_in  = '0;
            end
         end
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (chunk_start) begin
         phase_in = PH_HEADER;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_last) begin
                  phase_in = (chunk_len_hdr == 32'd0) ? PH_IDLE : PH_DELTA;
               end
            end
            PH_DELTA: begin
               if (vlq_fin) begin
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (st_chan) begin
                  phase_in = PH_DATA1;
               end else if (st_meta) begin
                  phase_in = PH_MTYPE;
               end else if (st_sysex) begin
                  phase_in = PH_LEN;
               end else if (!data_byte[7]) begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA1: phase_in = PH_DATA2;
            PH_MTYPE: phase_in = PH_LEN;
            PH_LEN: begin
               if (vlq_fin) begin
                  phase_in = PH_SKIP;
               end
            end
            default: ;
         endcase
         if (body) begin
            if (ev_err) begin
               phase_in = PH_ERROR;
            end else if (ev_end) begin
               phase_in = PH_IDLE;
            end else if (ev_done) begin
               phase_in = PH_DELTA;
            end
         end
      end
   end

   // Advance parse state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hdr_ff       <= '0;
         chunk_len_ff <= '0;
         seen_ff      <= '0;
         run_ff       <= '0;
         first_ff     <= '0;
         delta_ff     <= '0;
         len_ff       <= '0;
         vcnt_ff      <= '0;
         meta_ff      <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         hdr_ff       <= hdr_in;
         chunk_len_ff <= chunk_len_in;
         seen_ff      <= seen_in;
         run_ff       <= run_in;
         first_ff     <= first_in;
         delta_ff     <= delta_in;
         len_ff       <= len_in;
         vcnt_ff      <= vcnt_in;
         meta_ff      <= meta_in;
      end
   end

`ifndef SYNTHESIS
   a_quiet_outside_chunk: assert property (@(posedge clock) disable iff (reset)
      (take && !chunk_start && ((phase_ff == PH_IDLE) || (phase_ff == PH_ERROR)))
      |-> !result.valid)
      else $error("result produced outside a chunk");

   a_start_restarts_header: assert property (@(posedge clock) disable iff (reset)
      (take && chunk_start)
      |=> ((phase_ff == PH_HEADER) && (hdr_ff == 3'd1) && (chunk_len_ff == 32'd0)))
      else $error("chunk start did not restart the header");

   a_error_parks: assert property (@(posedge clock) disable iff (reset)
      (take && result.valid && (result.beat.kind == KIND_ERR)) |=> (phase_ff == PH_ERROR))
      else $error("format error did not park the parser");

   a_end_idles: assert property (@(posedge clock) disable iff (reset)
      (take && result.valid && (result.beat.kind == KIND_END)) |=> (phase_ff == PH_IDLE))
      else $error("chunk end did not leave the chunk");

   a_vlq_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_ERROR) |-> (vcnt_ff < VCNT_W'(MAX_VLQ_BYTES)))
      else $error("variable-length byte count out of range");
`endif

endmodule

[design/mtep_out_reg.sv]
// Result register that drives the event channel and frees the byte channel.
module mtep_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mtep_pkg::result_type result,
   output logic                 room,
   mtep_rsp_if.source           rsp_bus
);
   import mtep_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff;

   // Free when empty or being drained this cycle
   assign room = !valid_ff || rsp_bus.ready;

   // Load on each accepted byte, drop once taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result.valid;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until replaced
   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         beat_ff <= result.beat;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.kind          = beat_ff.kind;
   assign rsp_bus.delta_ticks   = beat_ff.delta_ticks;
   assign rsp_bus.short_message = beat_ff.short_message;
   assign rsp_bus.meta_type     = beat_ff.meta_type;

endmodule

[design/midi_track_event_parser.sv]
// Top level of the MIDI track event parser.
//
// req_bus carries one byte of a track chunk per beat; chunk_start marks the
// first ID byte of a chunk header and restarts parsing from any state.
// rsp_bus carries one event beat: kind (channel message, meta/SysEx skipped,
// chunk end, format error), delta time, packed short message and meta type.
// A byte produces at most one event beat; most bytes produce none.
// The event caused by a byte is registered and offered on rsp_bus in the
// cycle after that byte is accepted.
// Throughput: one byte per cycle while the result register has room; the parse
// state is updated in the same cycle that a byte is accepted, and the result
// register is refilled as it drains.
// When rsp_bus stalls with an event held, req_bus.ready follows
// rsp_bus.ready, so bytes keep flowing as long as the held event is taken.
// Reset clears the parse state; bytes are then ignored until chunk_start.
module midi_track_event_parser #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   mtep_req_if.sink   req_bus,
   mtep_rsp_if.source rsp_bus
);
   import mtep_pkg::*;

   result_type result;
   logic       room;
   logic       take;

   assign req_bus.ready = room;
   assign take          = req_bus.valid && room;

   mtep_parser #(
      .MAX_VLQ_BYTES (MAX_VLQ_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_bus.data_byte),
      .chunk_start (req_bus.chunk_start),
      .result      (result)
   );

   mtep_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (take),
      .result  (result),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule
